// ===== rtl/uyvy_to_planar_rotate_macros.svh =====
// ----------------------------------------------------------------------------
// UYVY to planar rotate assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UYVY_TO_PLANAR_ROTATE_MACROS_SVH
`define UYVY_TO_PLANAR_ROTATE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define UYROT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define UYROT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uyrot_pkg.sv =====
// ----------------------------------------------------------------------------
// UYVY to planar rotate package
// Shared widths, register indexes, types and the frame size clamp.
// ----------------------------------------------------------------------------
package uyrot_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = 13;
  localparam int ADDR_W   = 24;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_PORTRAIT_MODE  = 3'd2,
    CFG_LUMA_PITCH     = 3'd3,
    CFG_CHROMA_A_PITCH = 3'd4,
    CFG_CHROMA_B_PITCH = 3'd5
  } cfg_index_t;

  typedef logic [DIM_W-1:0] dim_t;

  typedef struct packed {
    dim_t c;
    dim_t r;
    logic keep;
    logic even;
    logic frame_end;
  } pos_t;

  typedef struct packed {
    dim_t x;
    dim_t y;
    dim_t add;
  } mac_op_t;

  // Clear bit 0, raise to two, cap at the largest supported size.
  function automatic dim_t eff_dim(input dim_t v);
    dim_t e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < dim_t'(2)) e = dim_t'(2);
    if (e > dim_t'(MAX_DIM)) e = dim_t'(MAX_DIM);
    return e;
  endfunction

endpackage

// ===== rtl/uyrot_pos_track.sv =====
// ----------------------------------------------------------------------------
// UYVY to planar rotate position tracker
// Column and row counters of the source frame, with keep and frame-end decode.
// ----------------------------------------------------------------------------
module uyrot_pos_track (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  uyrot_pkg::dim_t w,
  input  uyrot_pkg::dim_t h,
  input  logic          portrait,
  output uyrot_pkg::pos_t pos
);
  import uyrot_pkg::*;

  `include "uyvy_to_planar_rotate_macros.svh"

  dim_t column_pos, column_pos_next;
  dim_t row_pos, row_pos_next;
  dim_t c_eff, r_eff, limit, col_step, row_step;
  logic out_of_range;

  always_comb begin
    out_of_range = (column_pos >= w) || (row_pos >= h);
    c_eff = out_of_range ? '0 : column_pos;
    r_eff = out_of_range ? '0 : row_pos;
    limit = (portrait && (h < w)) ? h : w;
    col_step = c_eff + dim_t'(2);
    row_step = r_eff + dim_t'(1);

    pos.c = c_eff;
    pos.r = r_eff;
    pos.keep = c_eff < limit;
    pos.even = !r_eff[0];
    pos.frame_end = (r_eff == h - dim_t'(1)) && (col_step >= limit);

    if (col_step >= w) begin
      column_pos_next = '0;
      row_pos_next = (row_step >= h) ? '0 : row_step;
    end else begin
      column_pos_next = col_step;
      row_pos_next = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos <= '0;
    end else if (advance) begin
      column_pos <= column_pos_next;
      row_pos <= row_pos_next;
    end
  end

  `UYROT_ASSERT(a_column_even, !column_pos[0], "column counter left even pixel alignment")
  `UYROT_ASSERT(a_frame_end_kept, !pos.frame_end || pos.keep || !portrait || (h < w),
    "frame end decoded on a dropped word")
  `UYROT_ASSERT(a_pos_in_frame, (pos.c < w) && (pos.r < h), "position outside the frame")

endmodule

// ===== rtl/uyvy_to_planar_rotate.sv =====
// ----------------------------------------------------------------------------
// UYVY to planar rotate
// Packed UYVY camera words to luma and half-resolution chroma plane writes.
// ----------------------------------------------------------------------------
// Usage:
// One packed UYVY word enters on packed_word per transaction of the pixel
// channel (pixel_valid, pixel_stall); the block raises pixel_stall itself.
// Each kept word yields one result transaction on the result channel
// (result_valid, result_stall): two luma writes, on even source rows one
// write to each chroma plane, and frame_end on the last kept word of a frame.
// Words past the kept column limit in portrait mode leave no result.
// After a word is accepted, one register holds the decoded position and
// multiplier operands, and the next, which drives result_valid, holds the
// finished addresses after four parallel 13 by 13 multiply-adds.
// Throughput is one word per cycle while the receiver takes results.
// When result_stall is high the result holds, one more kept word can fill the
// operand register, and then pixel_stall rises.
// Configuration transactions on cfg_valid and cfg_ready are always taken and
// belong between frames while the block is empty.
// Reset clears both counters and the pipeline and loads the default
// 640 by 480 landscape setup.
// ----------------------------------------------------------------------------
module uyvy_to_planar_rotate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [uyrot_pkg::WORD_W-1:0]      packed_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uyrot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uyrot_pkg::DIM_W-1:0]       cfg_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [uyrot_pkg::ADDR_W-1:0]      luma0_addr,
  output logic [uyrot_pkg::BYTE_W-1:0]      luma0_value,
  output logic [uyrot_pkg::ADDR_W-1:0]      luma1_addr,
  output logic [uyrot_pkg::BYTE_W-1:0]      luma1_value,
  output logic                              chroma_valid,
  output logic [uyrot_pkg::ADDR_W-1:0]      chroma_a_addr,
  output logic [uyrot_pkg::BYTE_W-1:0]      chroma_a_value,
  output logic [uyrot_pkg::ADDR_W-1:0]      chroma_b_addr,
  output logic [uyrot_pkg::BYTE_W-1:0]      chroma_b_value,
  output logic                              frame_end
);
  import uyrot_pkg::*;

  `include "uyvy_to_planar_rotate_macros.svh"

  localparam int PROD_W = 2 * DIM_W;

  dim_t frame_width, frame_height, luma_pitch, chroma_a_pitch, chroma_b_pitch;
  logic portrait_mode;
  dim_t w, h, ly, cy;
  pos_t pos;
  logic accept, s1_free, s2_load;

  mac_op_t op_l0, op_l1, op_ca, op_cb;

  logic          s1_valid;
  logic          s1_keep;
  logic          s1_even;
  logic          s1_frame_end;
  logic [WORD_W-1:0] s1_word;
  mac_op_t       s1_l0, s1_l1, s1_ca, s1_cb;

  logic [PROD_W-1:0] prod_l0, prod_l1, prod_ca, prod_cb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= dim_t'(640);
      frame_height <= dim_t'(480);
      portrait_mode <= 1'b0;
      luma_pitch <= dim_t'(480);
      chroma_a_pitch <= dim_t'(240);
      chroma_b_pitch <= dim_t'(240);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width <= cfg_data;
        CFG_FRAME_HEIGHT:   frame_height <= cfg_data;
        CFG_PORTRAIT_MODE:  portrait_mode <= cfg_data[0];
        CFG_LUMA_PITCH:     luma_pitch <= cfg_data;
        CFG_CHROMA_A_PITCH: chroma_a_pitch <= cfg_data;
        CFG_CHROMA_B_PITCH: chroma_b_pitch <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w = eff_dim(frame_width);
  assign h = eff_dim(frame_height);

  uyrot_pos_track u_pos (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .w        (w),
    .h        (h),
    .portrait (portrait_mode),
    .pos      (pos)
  );

  // Flow control: the operand stage moves on when it is empty, holds a
  // dropped word, or the result register is free or being taken.
  assign s1_free = !s1_valid || !s1_keep || !result_valid || !result_stall;
  assign pixel_stall = !s1_free;
  assign accept = pixel_valid && !pixel_stall;
  assign s2_load = s1_valid && s1_keep && (!result_valid || !result_stall);

  always_comb begin
    ly = h - dim_t'(1) - pos.r;
    cy = {1'b0, h[DIM_W-1:1]} - dim_t'(1) - {1'b0, pos.r[DIM_W-1:1]};
    if (portrait_mode) begin
      op_l0 = '{x: pos.c, y: luma_pitch, add: ly};
      op_l1 = '{x: pos.c + dim_t'(1), y: luma_pitch, add: ly};
      op_ca = '{x: {1'b0, pos.c[DIM_W-1:1]}, y: chroma_a_pitch, add: cy};
      op_cb = '{x: {1'b0, pos.c[DIM_W-1:1]}, y: chroma_b_pitch, add: cy};
    end else begin
      op_l0 = '{x: pos.r, y: w, add: pos.c};
      op_l1 = '{x: pos.r, y: w, add: pos.c + dim_t'(1)};
      op_ca = '{x: {1'b0, pos.r[DIM_W-1:1]}, y: {1'b0, w[DIM_W-1:1]},
                add: {1'b0, pos.c[DIM_W-1:1]}};
      op_cb = op_ca;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_keep <= pos.keep;
      s1_even <= pos.even;
      s1_frame_end <= pos.frame_end;
      s1_word <= packed_word;
      s1_l0 <= op_l0;
      s1_l1 <= op_l1;
      s1_ca <= op_ca;
      s1_cb <= op_cb;
    end
  end

  assign prod_l0 = s1_l0.x * s1_l0.y;
  assign prod_l1 = s1_l1.x * s1_l1.y;
  assign prod_ca = s1_ca.x * s1_ca.y;
  assign prod_cb = s1_cb.x * s1_cb.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      luma0_addr <= ADDR_W'(prod_l0) + ADDR_W'(s1_l0.add);
      luma0_value <= s1_word[15:8];
      luma1_addr <= ADDR_W'(prod_l1) + ADDR_W'(s1_l1.add);
      luma1_value <= s1_word[31:24];
      chroma_valid <= s1_even;
      chroma_a_addr <= s1_even ? ADDR_W'(prod_ca) + ADDR_W'(s1_ca.add) : '0;
      chroma_a_value <= s1_even ? s1_word[23:16] : '0;
      chroma_b_addr <= s1_even ? ADDR_W'(prod_cb) + ADDR_W'(s1_cb.add) : '0;
      chroma_b_value <= s1_even ? s1_word[7:0] : '0;
      frame_end <= s1_frame_end;
    end
  end

  `UYROT_ASSERT(a_odd_row_chroma_zero,
    !result_valid || chroma_valid || ((chroma_a_addr == '0) && (chroma_b_value == '0)),
    "chroma fields not cleared on an odd source row")
  `UYROT_ASSERT_NEXT(a_kept_word_held, s1_valid && s1_keep && !s2_load,
    s1_valid && s1_keep, "kept word lost from the operand stage")
  `UYROT_ASSERT_NEXT(a_result_load, s2_load, result_valid,
    "result register did not take a kept word")

endmodule

// ===== sim/uyvy_to_planar_rotate_check.sv =====
// ----------------------------------------------------------------------------
// UYVY to planar rotate checker
// Watches the pixel, configuration and result channels of the converter.
// It keeps its own copy of the register file and the column and row counters,
// works out the plane writes of every accepted word and compares each result
// transaction, field by field, with the oldest outstanding write set.
// ----------------------------------------------------------------------------
module uyvy_to_planar_rotate_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  input  logic                            pixel_stall,
  input  logic [uyrot_pkg::WORD_W-1:0]    packed_word,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [uyrot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uyrot_pkg::DIM_W-1:0]     cfg_data,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [uyrot_pkg::ADDR_W-1:0]    luma0_addr,
  input  logic [uyrot_pkg::BYTE_W-1:0]    luma0_value,
  input  logic [uyrot_pkg::ADDR_W-1:0]    luma1_addr,
  input  logic [uyrot_pkg::BYTE_W-1:0]    luma1_value,
  input  logic                            chroma_valid,
  input  logic [uyrot_pkg::ADDR_W-1:0]    chroma_a_addr,
  input  logic [uyrot_pkg::BYTE_W-1:0]    chroma_a_value,
  input  logic [uyrot_pkg::ADDR_W-1:0]    chroma_b_addr,
  input  logic [uyrot_pkg::BYTE_W-1:0]    chroma_b_value,
  input  logic                            frame_end,
  output int                              mismatches,
  output int                              writes_pending
);
  import uyrot_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] luma0_addr;
    logic [BYTE_W-1:0] luma0_value;
    logic [ADDR_W-1:0] luma1_addr;
    logic [BYTE_W-1:0] luma1_value;
    logic              chroma_valid;
    logic [ADDR_W-1:0] chroma_a_addr;
    logic [BYTE_W-1:0] chroma_a_value;
    logic [ADDR_W-1:0] chroma_b_addr;
    logic [BYTE_W-1:0] chroma_b_value;
    logic              frame_end;
  } plane_write_t;

  dim_t         frame_width;
  dim_t         frame_height;
  logic         portrait_mode;
  dim_t         luma_pitch;
  dim_t         chroma_a_pitch;
  dim_t         chroma_b_pitch;
  int unsigned  column_pos;
  int unsigned  row_pos;
  plane_write_t pending_writes[$];

  function automatic int unsigned clamp_dim(input dim_t v);
    int unsigned d;
    int unsigned cap;
    cap = int'(MAX_DIM) & 32'hFFFF_FFFE;
    d = int'(v) & 32'hFFFF_FFFE;
    if (d < 2) d = 2;
    if (d > cap) d = cap;
    return d;
  endfunction

  // Returns 1 when the word is kept; the counters advance either way.
  function automatic bit map_word(input logic [WORD_W-1:0] word, output plane_write_t wr);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    int unsigned     r;
    int unsigned     limit;
    longint unsigned l0;
    longint unsigned l1;
    longint unsigned ca;
    longint unsigned cb;
    longint unsigned ly;
    longint unsigned cy;
    bit              even;
    bit              kept;
    w = clamp_dim(frame_width);
    h = clamp_dim(frame_height);
    if (column_pos >= w || row_pos >= h) begin
      column_pos = 0;
      row_pos = 0;
    end
    c = column_pos;
    r = row_pos;
    limit = (portrait_mode && h < w) ? h : w;
    even = (r % 2) == 0;
    kept = c < limit;
    ca = 0;
    cb = 0;
    if (!portrait_mode) begin
      l0 = 64'(r) * w + c;
      l1 = l0 + 1;
      ca = 64'(r / 2) * (w / 2) + c / 2;
      cb = ca;
    end else begin
      ly = h - 1 - r;
      l0 = 64'(c) * luma_pitch + ly;
      l1 = 64'(c + 1) * luma_pitch + ly;
      cy = h / 2 - 1 - r / 2;
      ca = 64'(c / 2) * chroma_a_pitch + cy;
      cb = 64'(c / 2) * chroma_b_pitch + cy;
    end
    wr = '0;
    wr.luma0_addr = l0[ADDR_W-1:0];
    wr.luma0_value = word[15:8];
    wr.luma1_addr = l1[ADDR_W-1:0];
    wr.luma1_value = word[31:24];
    wr.chroma_valid = even;
    if (even) begin
      wr.chroma_a_addr = ca[ADDR_W-1:0];
      wr.chroma_a_value = word[23:16];
      wr.chroma_b_addr = cb[ADDR_W-1:0];
      wr.chroma_b_value = word[7:0];
    end
    wr.frame_end = (r == h - 1) && (c + 2 >= limit);
    column_pos = c + 2;
    if (column_pos >= w) begin
      column_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return kept;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    plane_write_t want;
    if (rst) begin
      frame_width = 13'd640;
      frame_height = 13'd480;
      portrait_mode = 1'b0;
      luma_pitch = 13'd480;
      chroma_a_pitch = 13'd240;
      chroma_b_pitch = 13'd240;
      column_pos = 0;
      row_pos = 0;
      mismatches = 0;
      pending_writes.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_writes.size() == 0) begin
          $error("result transaction with no accepted word outstanding");
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          check_field("luma0_addr", want.luma0_addr, luma0_addr);
          check_field("luma0_value", want.luma0_value, luma0_value);
          check_field("luma1_addr", want.luma1_addr, luma1_addr);
          check_field("luma1_value", want.luma1_value, luma1_value);
          check_field("chroma_valid", want.chroma_valid, chroma_valid);
          check_field("chroma_a_addr", want.chroma_a_addr, chroma_a_addr);
          check_field("chroma_a_value", want.chroma_a_value, chroma_a_value);
          check_field("chroma_b_addr", want.chroma_b_addr, chroma_b_addr);
          check_field("chroma_b_value", want.chroma_b_value, chroma_b_value);
          check_field("frame_end", want.frame_end, frame_end);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            frame_width = cfg_data;
          end
          CFG_FRAME_HEIGHT: begin
            frame_height = cfg_data;
          end
          CFG_PORTRAIT_MODE: begin
            portrait_mode = cfg_data[0];
          end
          CFG_LUMA_PITCH: begin
            luma_pitch = cfg_data;
          end
          CFG_CHROMA_A_PITCH: begin
            chroma_a_pitch = cfg_data;
          end
          CFG_CHROMA_B_PITCH: begin
            chroma_b_pitch = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (pixel_valid && !pixel_stall) begin
        if (map_word(packed_word, want)) pending_writes.push_back(want);
      end
    end
    writes_pending = pending_writes.size();
  end

endmodule

// ===== sim/uyvy_to_planar_rotate_test.sv =====
// ----------------------------------------------------------------------------
// UYVY to planar rotate testbench
// Drives packed UYVY words and register setups into the converter and lets
// the checker compare every plane write. A short directed part covers the
// reset setup, extreme words, dropped portrait columns and clamped sizes;
// random phases follow with new sizes, modes and pitches, random idling on
// both channels and a full drain before every register setup.
// ----------------------------------------------------------------------------
module uyvy_to_planar_rotate_test;
  import uyrot_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 1500;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [WORD_W-1:0]    packed_word = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ADDR_W-1:0]    luma0_addr;
  logic [BYTE_W-1:0]    luma0_value;
  logic [ADDR_W-1:0]    luma1_addr;
  logic [BYTE_W-1:0]    luma1_value;
  logic                 chroma_valid;
  logic [ADDR_W-1:0]    chroma_a_addr;
  logic [BYTE_W-1:0]    chroma_a_value;
  logic [ADDR_W-1:0]    chroma_b_addr;
  logic [BYTE_W-1:0]    chroma_b_value;
  logic                 frame_end;

  int mismatches;
  int writes_pending;
  int idle_cycles = 0;
  int stall_left = 0;
  int words_sent = 0;
  bit calm = 1'b0;

  uyvy_to_planar_rotate i_dut (.*);

  uyvy_to_planar_rotate_check i_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("uyvy_to_planar_rotate_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return DIM_W'($urandom_range(0, 24));
    if (roll < 90) return DIM_W'($urandom_range(25, 200));
    if (roll < 95) return 13'h1FFF;
    return DIM_W'($urandom_range(4094, 8191));
  endfunction

  function automatic logic [DIM_W-1:0] pick_pitch();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return 13'h1FFF;
    if (roll < 60) return DIM_W'($urandom_range(0, 8191));
    return DIM_W'($urandom_range(1, 64));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return $urandom();
  endfunction

  initial forever begin
    @(negedge clk);
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      result_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Entered and left at a falling edge; valid stays high until the caller
  // either offers the next word or lowers it.
  task automatic send_word(input logic [WORD_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      packed_word <= $urandom();
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    packed_word <= word;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic settle();
    pixel_valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_setup(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                            input logic portrait, input logic [DIM_W-1:0] luma_p,
                            input logic [DIM_W-1:0] chroma_a_p,
                            input logic [DIM_W-1:0] chroma_b_p);
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    write_reg(CFG_PORTRAIT_MODE, {12'($urandom_range(0, 4095)), portrait});
    write_reg(CFG_LUMA_PITCH, luma_p);
    write_reg(CFG_CHROMA_A_PITCH, chroma_a_p);
    write_reg(CFG_CHROMA_B_PITCH, chroma_b_p);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, DIM_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_len;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setup: 640 by 480 landscape.
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);

    // Small landscape frame run to its end, with extreme words.
    settle();
    load_setup(13'd4, 13'd4, 1'b0, 13'd480, 13'd240, 13'd240);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    repeat (4) send_word(pick_word());

    // Portrait with columns past the height dropped and extreme pitches.
    settle();
    load_setup(13'd8, 13'd2, 1'b1, 13'h1FFF, 13'd0, 13'd1);
    repeat (8) send_word(pick_word());

    // Odd sizes are rounded down; height above width in portrait.
    settle();
    load_setup(13'd3, 13'd7, 1'b1, 13'd5, 13'd2, 13'd4095);
    repeat (5) send_word(pick_word());

    while (words_sent < RANDOM_WORDS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      load_setup(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)), pick_pitch(),
                 pick_pitch(), pick_pitch());
      phase_len = $urandom_range(10, 200);
      repeat (phase_len) send_word(pick_word());
    end

    settle();
    if (mismatches == 0 && writes_pending == 0) begin
      $display("uyvy_to_planar_rotate_test: done, clean");
    end else begin
      $display("uyvy_to_planar_rotate_test: done, errors");
    end
    $finish;
  end

endmodule
